@@ src/ufvp_pkg.sv @@
// ----------------------------------------------------------------------------
// Update file version picker package
// Shared types and constants: parse phases, parse state, function codes and
// the fixed suffix text of an update file name.
// ----------------------------------------------------------------------------
package ufvp_pkg;

  // Function codes carried in the input transaction
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_CHAR  = 1'b1;

  // Parse phase, one-hot
  typedef enum logic [5:0] {
    PH_V      = 6'b000001,
    PH_MAJOR  = 6'b000010,
    PH_MINOR  = 6'b000100,
    PH_BUILD  = 6'b001000,
    PH_SUFFIX = 6'b010000,
    PH_REJECT = 6'b100000
  } phase_t;

  // Per-name parse state
  typedef struct packed {
    phase_t      phase;
    logic [1:0]  digit_cnt;
    logic [9:0]  accum;
    logic [7:0]  major;
    logic [7:0]  minor;
    logic [7:0]  build;
    logic [4:0]  suffix_pos;
  } parse_st_t;

  localparam parse_st_t PARSE_CLEAR = '{
    phase:      PH_V,
    digit_cnt:  2'd0,
    accum:      10'd0,
    major:      8'd0,
    minor:      8'd0,
    build:      8'd0,
    suffix_pos: 5'd0
  };

  // Suffix text of an update file name in lower case, zero filled to 32 entries
  localparam logic [7:0] SUFFIX_TAB [32] = '{
    8'h5f, 8'h73, 8'h74, 8'h65, 8'h70, 8'h70, 8'h65, 8'h72,
    8'h5f, 8'h31, 8'h34, 8'h34, 8'h70, 8'h69, 8'h6e, 8'h2e,
    8'h62, 8'h69, 8'h6e, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  localparam logic [7:0] CHAR_V     = 8'h76;
  localparam logic [7:0] CHAR_UNDER = 8'h5f;
  localparam logic [7:0] FIELD_MAX  = 8'hff;

endpackage

@@ src/ufvp_parse.sv @@
// ----------------------------------------------------------------------------
// Update file version picker: name character step
// Advances the per-name parse state by one name character.
// ----------------------------------------------------------------------------
module ufvp_parse #(
  parameter int SUFFIX_LEN = 19,
  parameter int MAX_DIGITS = 3
) (
  input  ufvp_pkg::parse_st_t st,
  input  logic [7:0]          ch,
  output ufvp_pkg::parse_st_t st_nxt
);
  import ufvp_pkg::*;

  logic [7:0] ch_fold;
  logic       is_digit;
  logic [9:0] accum_step;
  logic       suffix_hit_cur;
  logic       suffix_hit_first;
  logic       field_ok;

  // Fold upper case letters to lower case
  always_comb begin
    ch_fold = ch;
    if (ch inside {[8'h41:8'h5a]}) begin
      ch_fold = ch + 8'h20;
    end
  end

  assign is_digit   = ch inside {[8'h30:8'h39]};
  assign accum_step = {st.accum[6:0], 3'b000} + {st.accum[8:0], 1'b0} + {6'd0, ch[3:0]};
  assign field_ok   = (st.digit_cnt != 2'd0) && (st.accum <= {2'b00, FIELD_MAX});

  assign suffix_hit_cur   = (st.suffix_pos < 5'(SUFFIX_LEN)) &&
                            (ch_fold == SUFFIX_TAB[st.suffix_pos]);
  assign suffix_hit_first = (ch_fold == SUFFIX_TAB[0]);

  // Walk the pattern
  always_comb begin
    st_nxt = st;
    case (st.phase)
      PH_V: begin
        if (ch_fold == CHAR_V) begin
          st_nxt.phase     = PH_MAJOR;
          st_nxt.digit_cnt = 2'd0;
          st_nxt.accum     = 10'd0;
        end else begin
          st_nxt.phase = PH_REJECT;
        end
      end
      PH_MAJOR, PH_MINOR, PH_BUILD: begin
        if (is_digit) begin
          if (st.digit_cnt < 2'(MAX_DIGITS)) begin
            st_nxt.accum     = accum_step;
            st_nxt.digit_cnt = st.digit_cnt + 2'd1;
          end else begin
            st_nxt.phase = PH_REJECT;
          end
        end else if (!field_ok) begin
          st_nxt.phase = PH_REJECT;
        end else if (st.phase == PH_BUILD) begin
          // Build field ends on the first suffix character
          st_nxt.build = st.accum[7:0];
          if (suffix_hit_first) begin
            st_nxt.phase      = PH_SUFFIX;
            st_nxt.suffix_pos = 5'd1;
          end else begin
            st_nxt.phase      = PH_REJECT;
            st_nxt.suffix_pos = 5'd0;
          end
        end else if (ch != CHAR_UNDER) begin
          st_nxt.phase = PH_REJECT;
        end else begin
          if (st.phase == PH_MAJOR) begin
            st_nxt.major = st.accum[7:0];
            st_nxt.phase = PH_MINOR;
          end else begin
            st_nxt.minor = st.accum[7:0];
            st_nxt.phase = PH_BUILD;
          end
          st_nxt.digit_cnt = 2'd0;
          st_nxt.accum     = 10'd0;
        end
      end
      PH_SUFFIX: begin
        if (suffix_hit_cur) begin
          st_nxt.suffix_pos = st.suffix_pos + 5'd1;
        end else begin
          st_nxt.phase = PH_REJECT;
        end
      end
      default: begin
        st_nxt.phase = PH_REJECT;
      end
    endcase
  end

endmodule

@@ src/update_filename_version_picker_core.sv @@
// ----------------------------------------------------------------------------
// Update file version picker core
// Checks directory entry names against v<major>_<minor>_<build><suffix> and
// keeps the highest version seen in the current walk.
// ----------------------------------------------------------------------------
// The block takes one name character per cycle and sustains one transaction
// per clock, except that a name's last character waits in the input register
// while an earlier result is stalled. Each transaction passes an input
// register and then a result register, with a combinational parse step on
// the registered parse state between them. A transaction with in_tuser[0] low
// starts a new walk: it clears the parse state, the best version and the match
// count and produces no result. Only the last character of a name (in_tlast
// high) produces a result. A stalled result is held in the output register
// while the next characters still enter, until the next result needs it.
module update_filename_version_picker_core #(
  parameter int SUFFIX_LEN = 19,
  parameter int MAX_DIGITS = 3,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic [1:0]  in_tuser,   // [0] func, [1] is_dir
  input  logic        in_tlast,   // name_last
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [7:0] major_field, [15:8] minor_field,
                                  // [23:16] build_field, [47:24] best_packed,
                                  // [63:48] match_count
  output logic [1:0]  out_tuser   // [0] matched, [1] new_best
);
  import ufvp_pkg::*;

  // Input register
  logic        s1_valid_r, s1_valid_nxt;
  logic        s1_func_r;
  logic [7:0]  s1_ch_r;
  logic        s1_last_r;
  logic        s1_dir_r;

  // Walk state
  parse_st_t             parse_r, parse_nxt;
  parse_st_t             step;
  logic [23:0]           best_r, best_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [31:0]           cnt_ext;

  // Result register
  logic        out_valid_r, out_valid_nxt;
  logic        matched_r, matched_nxt;
  logic        new_best_r, new_best_nxt;
  logic [7:0]  major_r, major_nxt;
  logic [7:0]  minor_r, minor_nxt;
  logic [7:0]  build_r, build_nxt;
  logic [23:0] best_out_r, best_out_nxt;
  logic [15:0] count_out_r, count_out_nxt;

  logic        produces;
  logic        out_free;
  logic        s1_fire;
  logic        s1_start;
  logic        ok;
  logic [23:0] version;

  ufvp_parse #(
    .SUFFIX_LEN (SUFFIX_LEN),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_parse (
    .st     (parse_r),
    .ch     (s1_ch_r),
    .st_nxt (step)
  );

  // Handshake: the held item moves on unless it needs a busy result slot
  assign s1_start  = (s1_func_r == FUNC_START);
  assign produces  = (s1_func_r == FUNC_CHAR) && s1_last_r;
  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && (!produces || out_free);
  assign in_tready = !s1_valid_r || s1_fire;

  assign ok      = (step.phase == PH_SUFFIX) && (step.suffix_pos == 5'(SUFFIX_LEN)) &&
                   !s1_dir_r;
  assign version = {step.major, step.minor, step.build};
  assign cnt_ext = 32'(cnt_r);

  // Next state
  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    parse_nxt     = parse_r;
    best_nxt      = best_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    matched_nxt   = matched_r;
    new_best_nxt  = new_best_r;
    major_nxt     = major_r;
    minor_nxt     = minor_r;
    build_nxt     = build_r;
    best_out_nxt  = best_out_r;
    count_out_nxt = count_out_r;

    if (in_tready) begin
      s1_valid_nxt = in_tvalid;
    end

    if (s1_fire) begin
      if (s1_start) begin
        parse_nxt = PARSE_CLEAR;
        best_nxt  = 24'd0;
        cnt_nxt   = '0;
      end else if (!s1_last_r) begin
        parse_nxt = step;
      end else begin
        parse_nxt    = PARSE_CLEAR;
        new_best_nxt = 1'b0;
        if (ok) begin
          if (cnt_r != {COUNT_BITS{1'b1}}) begin
            cnt_nxt = cnt_r + COUNT_BITS'(1);
          end
          if (version > best_r) begin
            best_nxt     = version;
            new_best_nxt = 1'b1;
          end
        end
        out_valid_nxt = 1'b1;
        matched_nxt   = ok;
        major_nxt     = ok ? step.major : 8'd0;
        minor_nxt     = ok ? step.minor : 8'd0;
        build_nxt     = ok ? step.build : 8'd0;
        best_out_nxt  = best_nxt;
        count_out_nxt = 32'(cnt_nxt) >> 0 == 32'd0 ? 16'd0 : 16'(32'(cnt_nxt));
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      parse_r     <= PARSE_CLEAR;
      best_r      <= 24'd0;
      cnt_r       <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      parse_r     <= parse_nxt;
      best_r      <= best_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_tready) begin
      s1_func_r <= in_tuser[0];
      s1_ch_r   <= in_tdata;
      s1_last_r <= in_tlast;
      s1_dir_r  <= in_tuser[1];
    end
    matched_r   <= matched_nxt;
    new_best_r  <= new_best_nxt;
    major_r     <= major_nxt;
    minor_r     <= minor_nxt;
    build_r     <= build_nxt;
    best_out_r  <= best_out_nxt;
    count_out_r <= count_out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {new_best_r, matched_r};
  assign out_tdata  = {count_out_r, best_out_r, build_r, minor_r, major_r};

  // A rejected name reports zero fields and never becomes the best
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !matched_r) |->
      (major_r == 8'd0 && minor_r == 8'd0 && build_r == 8'd0 && !new_best_r))
    else $error("rejected name carries fields");

  // A new best reports its own version as the best
  a_new_best_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && new_best_r) |-> (best_out_r == {major_r, minor_r, build_r}))
    else $error("new best does not match reported best");

  // A start transaction clears the walk totals
  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_start) |=> (best_r == 24'd0 && cnt_r == '0))
    else $error("start did not clear walk totals");

  // Best version and count only grow within a walk
  a_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_fire && s1_start) |=> (best_r >= $past(best_r) && cnt_r >= $past(cnt_r)))
    else $error("walk totals decreased");

  // Reported count follows the stored count after a result
  a_count_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && produces) |=> (count_out_r == cnt_ext[15:0]))
    else $error("reported count differs from stored count");

endmodule
